/* hw/rtl/tfas_pkg.sv */
// Package for the truncating float32 add/sub pipeline.
// Holds the stage payload types passed between the pipeline modules, and HiddenBit.
`default_nettype none
package tfas_pkg;
  localparam logic [23:0] HiddenBit = 24'h800000;

  typedef struct packed {
    logic        is_sub;
    logic        zero_res;
    logic        sign;
    logic [7:0]  exp;
    logic [23:0] m1;
    logic [23:0] m2;
  } align_t;

  typedef struct packed {
    logic        is_sub;
    logic        zero_res;
    logic        sign;
    logic [7:0]  exp;
    logic [24:0] m;
  } sum_t;
endpackage
`default_nettype wire

/* hw/rtl/tfas_if.sv */
// Valid/ready channel interfaces for the float32 add/sub block.
// Depends on nothing.
`default_nettype none
interface tfas_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

interface tfas_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  modport source (output valid, result_bits, input ready);
  modport sink (input valid, result_bits, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tfas_align.sv */
// Stage 1: unpack, resolve operation and sign mixing, align smaller operand.
// Depends on tfas_pkg.
`default_nettype none
module tfas_align (
  input  wire logic        action,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output tfas_pkg::align_t q
);
  logic        sa, sb, sub, s;
  logic [7:0]  ea, eb, e1, e2;
  logic [22:0] fa, fb, f1, f2;
  logic [23:0] m1, m2;
  logic [7:0]  d;
  always_comb begin
    sa = operand_a[31]; ea = operand_a[30:23]; fa = operand_a[22:0];
    sb = operand_b[31]; eb = operand_b[30:23]; fb = operand_b[22:0];
    sub = action ^ (sa != sb);
    // swap operands when adding negative a to positive b
    if (!action && sa && !sb) begin
      s = 1'b0; e1 = eb; f1 = fb; e2 = ea; f2 = fa;
    end else begin
      s = (sa != sb) ? 1'b0 : sa;
      if (action || sa == sb) s = sa;
      if (!action && sa != sb) s = 1'b0;
      e1 = ea; f1 = fa; e2 = eb; f2 = fb;
    end
    m1 = {(e1 != 8'd0), f1};
    m2 = {(e2 != 8'd0), f2};
    q.is_sub = sub;
    q.zero_res = sub && (e1 == e2) && (f1 == f2);
    q.sign = s;
    if (e1 > e2) begin
      d = e1 - e2;
      q.m1 = m1;
      q.m2 = (d >= 8'd32) ? 24'd0 : (m2 >> d[4:0]);
      q.exp = e1;
    end else begin
      d = e2 - e1;
      q.m1 = (d >= 8'd32) ? 24'd0 : (m1 >> d[4:0]);
      q.m2 = m2;
      q.exp = e2;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/tfas_combine.sv */
// Stage 2: add or subtract aligned mantissas, apply subtract adjust.
// Depends on tfas_pkg.
`default_nettype none
module tfas_combine (
  input  tfas_pkg::align_t d,
  output tfas_pkg::sum_t   q
);
  logic [23:0] diff;
  always_comb begin
    q.is_sub = d.is_sub;
    q.zero_res = d.zero_res;
    q.exp = d.exp;
    q.sign = d.sign;
    diff = 24'd0;
    if (!d.is_sub) begin
      q.m = {1'b0, d.m1} + {1'b0, d.m2};
    end else begin
      if (d.m1 >= d.m2) diff = d.m1 - d.m2;
      else begin
        diff = d.m2 - d.m1;
        q.sign = ~d.sign;
      end
      if (diff[23] && d.m1 != 24'd0 && d.m2 != 24'd0) diff = diff - 24'd1;
      q.m = {1'b0, diff};
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/tfas_norm.sv */
// Stage 3: normalize (carry right or leading-zero left, stopping at exp 0), pack.
// Depends on tfas_pkg.
`default_nettype none
module tfas_norm (
  input  tfas_pkg::sum_t d,
  output logic [31:0]    result_bits
);
  logic [4:0]  lz;
  logic [4:0]  sh;
  logic [7:0]  e;
  logic [23:0] m;
  logic [8:0]  einc;
  always_comb begin
    lz = 5'd24;
    for (int i = 0; i < 24; i++) if (d.m[i]) lz = 5'(23 - i);
    e = d.exp; m = d.m[23:0]; einc = 9'd0; sh = 5'd0;
    result_bits = 32'd0;
    if (d.zero_res) begin
      result_bits = 32'd0;
    end else if (!d.is_sub) begin
      if (d.m[24]) begin
        einc = {1'b0, d.exp} + 9'd1;
        m = d.m[24:1];
        e = einc[7:0];
      end
      if (d.m[24] && einc >= 9'd255) begin
        result_bits = {d.sign, 8'hFF, 23'd0};
      end else begin
        // drop the hidden bit; a denormal carry lands in the exponent field
        if (e != 8'd0) m = m - tfas_pkg::HiddenBit;
        result_bits = {d.sign, e, 23'd0} | {8'd0, m};
      end
    end else begin
      sh = ({3'd0, lz} > {1'b0, d.exp}) ? d.exp[4:0] : lz;
      m = d.m[23:0] << sh;
      e = d.exp - {3'd0, sh};
      if (e != 8'd0) m = m - tfas_pkg::HiddenBit;
      result_bits = {d.sign, 31'd0} + {1'b0, e, 23'd0} + {8'd0, m};
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/truncating_float32_add_sub.sv */
// Top level of the truncating float32 add/sub pipeline.
// Depends on tfas_pkg, tfas_if, tfas_align, tfas_combine, tfas_norm.
//
//  channel   dir  fields
//  in        in   action, operand_a, operand_b
//  out       out  result_bits
//
// Results pass through three registers (align, combine, normalize); one word a cycle while the output does not stall.
// The stall chain runs back from the output: a stage advances when it is
// empty or the stage after it advances; nothing is dropped or repeated.
// rst (synchronous) clears the valid bits only.
`default_nettype none
module truncating_float32_add_sub (
  input wire logic clk,
  input wire logic rst,
  tfas_in_if.sink  in,
  tfas_out_if.source out
);
  tfas_pkg::align_t a_next, a_q;
  tfas_pkg::sum_t   s_next, s_q;
  logic [31:0]      r_next, r_q;
  logic v1, v2, v3, adv1, adv2, adv3;

  tfas_align u_align (.action(in.action), .operand_a(in.operand_a),
                      .operand_b(in.operand_b), .q(a_next));
  tfas_combine u_comb (.d(a_q), .q(s_next));
  tfas_norm u_norm (.d(s_q), .result_bits(r_next));

  // advance each stage when its successor can take the word
  assign adv3 = !v3 || out.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in.ready = adv1;
  assign out.valid = v3;
  assign out.result_bits = r_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
    if (adv1) a_q <= a_next;
    if (adv2) s_q <= s_next;
    if (adv3) r_q <= r_next;
  end
endmodule
`default_nettype wire

/* hw/rtl/tfas_check.sv */
// Port-level checker for truncating_float32_add_sub, with its bind.
// Depends on tfas_if; its bind depends on truncating_float32_add_sub.
`default_nettype none
module tfas_check (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] result_bits
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_bits)) else $error("stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("ready");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("reset");
endmodule

bind truncating_float32_add_sub tfas_check u_chk (.clk(clk), .rst(rst),
  .in_ready(in.ready), .out_valid(out.valid),
  .out_ready(out.ready), .result_bits(out.result_bits));
`default_nettype wire
